### sv/tfn_pkg.sv
// shared widths, latency and control struct for the triangle face normal unit
// no dependencies
package tfn_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int EDGE_W      = COORD_WIDTH + 1;
  localparam int PROD_W      = 2 * EDGE_W;
  localparam int CROSS_W     = PROD_W + 1;
  localparam int LEN_W       = $clog2(CROSS_W + 1);
  localparam int MAG_W       = 16;
  localparam int SHIFT_W     = $clog2(CROSS_W - MAG_W + 1);
  localparam int SQ_W        = 2 * MAG_W;
  localparam int SUM_W       = SQ_W + 2;
  localparam int NORM_W      = 16;
  localparam int QUO_W       = 31;
  localparam int REM_W       = SUM_W + 1;
  localparam int ROOT_W      = 16;
  localparam int SQR_REM_W   = ROOT_W + 4;
  localparam int DIV_STAGES  = (QUO_W + 1) / 2;
  localparam int SQRT_STAGES = ROOT_W / 2;
  localparam int TOP_STAGES  = 8;
  localparam int LATENCY     = TOP_STAGES + 1 + DIV_STAGES + SQRT_STAGES + 1;

  typedef struct packed {
    logic valid;
    logic neg;
    logic degen;
  } tfn_ctl_t;

endpackage

### sv/tfn_unit_mag.sv
// pipelined unit magnitude of one component: floor(2^30 r^2 / sum), square root, round
// depends on tfn_pkg
module tfn_unit_mag (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tfn_pkg::tfn_ctl_t                   ctl_i,
  input  logic [tfn_pkg::SQ_W-1:0]            r2_i,
  input  logic [tfn_pkg::SUM_W-1:0]           sum_i,
  output logic                                valid_o,
  output logic signed [tfn_pkg::NORM_W-1:0]   norm_o
);
  import tfn_pkg::*;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
  } div_t;

  typedef struct packed {
    logic [SQR_REM_W-1:0] rem;
    logic [ROOT_W-1:0]    root;
    logic [QUO_W:0]       rad;
  } sqr_t;

  // two restoring division steps, step t feeds dividend bit lsb at t == 0 else zero
  function automatic div_t div_steps(div_t x, logic [SUM_W-1:0] den, logic lsb, int t0);
    div_t             y;
    logic [REM_W-1:0] remx;
    y = x;
    for (int k = 0; k < 2; k++) begin
      if (t0 + k < QUO_W) begin
        remx = {y.rem[REM_W-2:0], (t0 + k == 0) ? lsb : 1'b0};
        if (remx >= REM_W'(den)) begin
          y.rem = remx - REM_W'(den);
          y.quo = {y.quo[QUO_W-2:0], 1'b1};
        end else begin
          y.rem = remx;
          y.quo = {y.quo[QUO_W-2:0], 1'b0};
        end
      end
    end
    return y;
  endfunction

  // two digit-by-digit square root steps
  function automatic sqr_t sqr_steps(sqr_t x);
    sqr_t                 y;
    logic [SQR_REM_W-1:0] remx;
    logic [SQR_REM_W-1:0] trial;
    y = x;
    for (int k = 0; k < 2; k++) begin
      remx  = {y.rem[SQR_REM_W-3:0], y.rad[QUO_W:QUO_W-1]};
      trial = SQR_REM_W'({y.root, 2'b01});
      if (remx >= trial) begin
        y.rem  = remx - trial;
        y.root = {y.root[ROOT_W-2:0], 1'b1};
      end else begin
        y.rem  = remx;
        y.root = {y.root[ROOT_W-2:0], 1'b0};
      end
      y.rad = {y.rad[QUO_W-2:0], 2'b00};
    end
    return y;
  endfunction

  localparam int NST = DIV_STAGES + SQRT_STAGES + 1;

  tfn_ctl_t         ctl_q [NST+1];
  div_t             div_q [DIV_STAGES+1];
  logic [SUM_W-1:0] den_q [DIV_STAGES+1];
  logic             lsb_q;
  sqr_t             sqr_q [SQRT_STAGES+1];
  logic [ROOT_W:0]  half_d;

  // control travels down the whole pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= NST; i++) ctl_q[i] <= '0;
    end else begin
      ctl_q[0] <= ctl_i;
      for (int i = 1; i <= NST; i++) ctl_q[i] <= ctl_q[i-1];
    end
  end

  // entry: high dividend bits already below the divisor
  always_ff @(posedge clk_i) begin
    div_q[0].rem <= REM_W'(r2_i[SQ_W-1:1]);
    div_q[0].quo <= '0;
    den_q[0]     <= sum_i;
    lsb_q        <= r2_i[0];
  end

  // division stages
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    always_ff @(posedge clk_i) begin
      div_q[g+1] <= div_steps(div_q[g], den_q[g], lsb_q, 2 * g);
      den_q[g+1] <= den_q[g];
    end
  end

  // square root stages
  always_comb begin
    sqr_q[0].rem  = '0;
    sqr_q[0].root = '0;
    sqr_q[0].rad  = {1'b0, div_q[DIV_STAGES].quo};
  end

  for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_sqr
    sqr_t st;
    always_ff @(posedge clk_i) begin
      st <= sqr_steps((g == 0) ? sqr_q[0] : sqr_q[g]);
    end
    assign sqr_q[g+1] = st;
  end

  // round to nearest, apply sign, clear for degenerate
  assign half_d = ((ROOT_W + 1)'(sqr_q[SQRT_STAGES].root) + (ROOT_W + 1)'(1)) >> 1;

  always_ff @(posedge clk_i) begin
    if (ctl_q[NST-1].degen) begin
      norm_o <= '0;
    end else if (ctl_q[NST-1].neg) begin
      norm_o <= -NORM_W'(half_d[ROOT_W-1:0]);
    end else begin
      norm_o <= NORM_W'(half_d[ROOT_W-1:0]);
    end
  end

  assign valid_o = ctl_q[NST].valid;

endmodule

### sv/triangle_face_normal_unit.sv
// triangle face normal: edges, cross product, scale to unit length in Q1.14
// depends on tfn_pkg and tfn_unit_mag
//
//   channel  | handshake          | payload
//   request  | start_i, busy_o    | a_*_i, b_*_i, c_*_i (Q7.8)
//   result   | done_o (one cycle) | normal_*_o (Q1.14), degenerate_o
//
// a request is taken in every cycle; busy_o stays low
// each result passes through eight front stages, one entry stage, the
// 31-step division and 16-step square root at two steps per stage, and one
// rounding stage
// reset clears the valid bits and lane control; the receiver cannot stall
module triangle_face_normal_unit (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  output logic                                   busy_o,
  input  logic signed [tfn_pkg::COORD_WIDTH-1:0] a_x_i,
  input  logic signed [tfn_pkg::COORD_WIDTH-1:0] a_y_i,
  input  logic signed [tfn_pkg::COORD_WIDTH-1:0] a_z_i,
  input  logic signed [tfn_pkg::COORD_WIDTH-1:0] b_x_i,
  input  logic signed [tfn_pkg::COORD_WIDTH-1:0] b_y_i,
  input  logic signed [tfn_pkg::COORD_WIDTH-1:0] b_z_i,
  input  logic signed [tfn_pkg::COORD_WIDTH-1:0] c_x_i,
  input  logic signed [tfn_pkg::COORD_WIDTH-1:0] c_y_i,
  input  logic signed [tfn_pkg::COORD_WIDTH-1:0] c_z_i,
  output logic                                   done_o,
  output logic signed [tfn_pkg::NORM_W-1:0]      normal_x_o,
  output logic signed [tfn_pkg::NORM_W-1:0]      normal_y_o,
  output logic signed [tfn_pkg::NORM_W-1:0]      normal_z_o,
  output logic                                   degenerate_o
);
  import tfn_pkg::*;

  function automatic logic [LEN_W-1:0] bit_len(logic [CROSS_W-1:0] m);
    logic [LEN_W-1:0] n;
    n = '0;
    for (int i = 0; i < CROSS_W; i++) if (m[i]) n = LEN_W'(i + 1);
    return n;
  endfunction

  logic [TOP_STAGES:1]       vld_q;
  logic signed [EDGE_W-1:0]  u_q [3];
  logic signed [EDGE_W-1:0]  v_q [3];
  logic signed [PROD_W-1:0]  p_q [6];
  logic signed [CROSS_W-1:0] cr_q [3];
  logic [CROSS_W-1:0]        mag4_q [3];
  logic [CROSS_W-1:0]        mag5_q [3];
  logic [2:0]                neg4_q, neg5_q, neg6_q, neg7_q, neg8_q;
  logic                      dg4_q, dg5_q, dg6_q, dg7_q, dg8_q;
  logic [SHIFT_W-1:0]        sh_q;
  logic [MAG_W-1:0]          r_q [3];
  logic [SQ_W-1:0]           r2_q [3];
  logic [SQ_W-1:0]           r2b_q [3];
  logic [SUM_W-1:0]          sum_q;
  logic [LEN_W-1:0]          len_d;
  logic [2:0]                lane_vld;
  tfn_ctl_t                  ctl_d [3];
  logic signed [NORM_W-1:0]  norm_d [3];

  assign busy_o = 1'b0;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[TOP_STAGES-1:1], start_i & ~busy_o};
    end
  end

  assign len_d = bit_len(mag4_q[0] | mag4_q[1] | mag4_q[2]);

  // front stages: edges, products, cross, magnitude, shift, squares, sum
  always_ff @(posedge clk_i) begin
    u_q[0] <= EDGE_W'(b_x_i) - EDGE_W'(a_x_i);
    u_q[1] <= EDGE_W'(b_y_i) - EDGE_W'(a_y_i);
    u_q[2] <= EDGE_W'(b_z_i) - EDGE_W'(a_z_i);
    v_q[0] <= EDGE_W'(c_x_i) - EDGE_W'(a_x_i);
    v_q[1] <= EDGE_W'(c_y_i) - EDGE_W'(a_y_i);
    v_q[2] <= EDGE_W'(c_z_i) - EDGE_W'(a_z_i);

    p_q[0] <= u_q[1] * v_q[2];
    p_q[1] <= u_q[2] * v_q[1];
    p_q[2] <= u_q[2] * v_q[0];
    p_q[3] <= u_q[0] * v_q[2];
    p_q[4] <= u_q[0] * v_q[1];
    p_q[5] <= u_q[1] * v_q[0];

    for (int i = 0; i < 3; i++) begin
      cr_q[i] <= CROSS_W'(p_q[2*i]) - CROSS_W'(p_q[2*i+1]);
    end

    for (int i = 0; i < 3; i++) begin
      neg4_q[i] <= cr_q[i][CROSS_W-1];
      mag4_q[i] <= cr_q[i][CROSS_W-1] ? CROSS_W'(-cr_q[i]) : CROSS_W'(cr_q[i]);
    end
    dg4_q <= (cr_q[0] == '0) && (cr_q[1] == '0) && (cr_q[2] == '0);

    sh_q   <= (len_d > LEN_W'(MAG_W)) ? SHIFT_W'(len_d - LEN_W'(MAG_W)) : '0;
    mag5_q <= mag4_q;
    neg5_q <= neg4_q;
    dg5_q  <= dg4_q;

    for (int i = 0; i < 3; i++) r_q[i] <= MAG_W'(mag5_q[i] >> sh_q);
    neg6_q <= neg5_q;
    dg6_q  <= dg5_q;

    for (int i = 0; i < 3; i++) r2_q[i] <= SQ_W'(r_q[i]) * SQ_W'(r_q[i]);
    neg7_q <= neg6_q;
    dg7_q  <= dg6_q;

    sum_q  <= SUM_W'(r2_q[0]) + SUM_W'(r2_q[1]) + SUM_W'(r2_q[2]);
    r2b_q  <= r2_q;
    neg8_q <= neg7_q;
    dg8_q  <= dg7_q;
  end

  // one unit magnitude lane per component
  for (genvar i = 0; i < 3; i++) begin : g_lane
    always_comb begin
      ctl_d[i].valid = vld_q[TOP_STAGES];
      ctl_d[i].neg   = neg8_q[i];
      ctl_d[i].degen = dg8_q;
    end
    tfn_unit_mag u_mag (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl_d[i]),
      .r2_i    (r2b_q[i]),
      .sum_i   (sum_q),
      .valid_o (lane_vld[i]),
      .norm_o  (norm_d[i])
    );
  end

  // degenerate flag delayed alongside the lanes
  logic [LATENCY-TOP_STAGES-1:0] dg_line_q;
  always_ff @(posedge clk_i) begin
    dg_line_q <= {dg_line_q[LATENCY-TOP_STAGES-2:0], dg8_q};
  end

  assign done_o       = lane_vld[0] & lane_vld[1] & lane_vld[2];
  assign normal_x_o   = norm_d[0];
  assign normal_y_o   = norm_d[1];
  assign normal_z_o   = norm_d[2];
  assign degenerate_o = dg_line_q[LATENCY-TOP_STAGES-1];

endmodule

### sv/tfn_checker.sv
// port-level checks on the triangle face normal unit, bound to the top level
// depends on tfn_pkg and triangle_face_normal_unit
module tfn_checker (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   start_i,
  input logic                                   busy_o,
  input logic signed [tfn_pkg::COORD_WIDTH-1:0] a_x_i,
  input logic signed [tfn_pkg::COORD_WIDTH-1:0] a_y_i,
  input logic signed [tfn_pkg::COORD_WIDTH-1:0] a_z_i,
  input logic signed [tfn_pkg::COORD_WIDTH-1:0] b_x_i,
  input logic signed [tfn_pkg::COORD_WIDTH-1:0] b_y_i,
  input logic signed [tfn_pkg::COORD_WIDTH-1:0] b_z_i,
  input logic signed [tfn_pkg::COORD_WIDTH-1:0] c_x_i,
  input logic signed [tfn_pkg::COORD_WIDTH-1:0] c_y_i,
  input logic signed [tfn_pkg::COORD_WIDTH-1:0] c_z_i,
  input logic                                   done_o,
  input logic signed [tfn_pkg::NORM_W-1:0]      normal_x_o,
  input logic signed [tfn_pkg::NORM_W-1:0]      normal_y_o,
  input logic signed [tfn_pkg::NORM_W-1:0]      normal_z_o,
  input logic                                   degenerate_o
);
  import tfn_pkg::*;

  // every request yields a result after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##LATENCY done_o)
    else $error("result missing after request");

  // no result without a request
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LATENCY))
    else $error("result without request");

  // degenerate result carries a zero normal
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && degenerate_o |-> normal_x_o == 0 && normal_y_o == 0 && normal_z_o == 0)
    else $error("degenerate result with nonzero normal");

  // coincident vertices give a degenerate result
  a_coincident: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && a_x_i == b_x_i && a_y_i == b_y_i && a_z_i == b_z_i
      && a_x_i == c_x_i && a_y_i == c_y_i && a_z_i == c_z_i
      |-> ##LATENCY degenerate_o)
    else $error("coincident vertices not flagged");

  // components stay within plus or minus one
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> normal_x_o <= 16384 && normal_x_o >= -16384
      && normal_y_o <= 16384 && normal_y_o >= -16384
      && normal_z_o <= 16384 && normal_z_o >= -16384)
    else $error("normal component out of range");

endmodule

bind triangle_face_normal_unit tfn_checker u_tfn_checker (.*);

### tb/triangle_face_normal_unit_test.sv
// testbench for the triangle face normal unit: directed and random triangles,
// scoreboard predicts each unit normal; depends on tfn_pkg and the unit RTL
module triangle_face_normal_unit_test;
  import tfn_pkg::*;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    logic signed [NORM_W-1:0] nx;
    logic signed [NORM_W-1:0] ny;
    logic signed [NORM_W-1:0] nz;
    logic                     degen;
  } normal_t;

  // scoreboard: predicts the unit normal of each accepted request
  class normal_scoreboard;
    normal_t pending_q[$];
    int      errors;
    int      checked;
    int      degen_seen;

    function logic [15:0] scale_mag(longint unsigned r, longint unsigned sum);
      longint unsigned lo, hi, mid, t, rhs;
      lo  = 0;
      hi  = 16384;
      rhs = (r * r) << 30;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        t   = 2 * mid - 1;
        if (t * t * sum <= rhs) lo = mid;
        else hi = mid - 1;
      end
      return lo[15:0];
    endfunction

    function void note_request(coord_t p[9]);
      logic signed [63:0]  u[3], w[3];
      logic signed [127:0] cr[3];
      logic        [127:0] mag[3];
      logic                neg[3];
      int                  len, sh, i;
      longint unsigned     r[3], sum;
      logic        [15:0]  n;
      normal_t             e;
      for (i = 0; i < 3; i++) begin
        u[i] = 64'(p[3+i]) - 64'(p[i]);
        w[i] = 64'(p[6+i]) - 64'(p[i]);
      end
      cr[0] = 128'(u[1]) * 128'(w[2]) - 128'(u[2]) * 128'(w[1]);
      cr[1] = 128'(u[2]) * 128'(w[0]) - 128'(u[0]) * 128'(w[2]);
      cr[2] = 128'(u[0]) * 128'(w[1]) - 128'(u[1]) * 128'(w[0]);
      len = 0;
      for (i = 0; i < 3; i++) begin
        neg[i] = cr[i][127];
        mag[i] = neg[i] ? -cr[i] : cr[i];
        for (int b = 127; b >= 0; b--)
          if (mag[i][b]) begin
            if (b + 1 > len) len = b + 1;
            break;
          end
      end
      e = '0;
      if (len == 0) begin
        e.degen = 1'b1;
      end else begin
        sh  = len > 16 ? len - 16 : 0;
        sum = 0;
        for (i = 0; i < 3; i++) begin
          r[i] = 64'((mag[i] >> sh) & 128'hFFFF);
          sum += r[i] * r[i];
        end
        n = scale_mag(r[0], sum); e.nx = neg[0] ? -n : n;
        n = scale_mag(r[1], sum); e.ny = neg[1] ? -n : n;
        n = scale_mag(r[2], sum); e.nz = neg[2] ? -n : n;
      end
      pending_q.insert(pending_q.size(), e);
    endfunction

    function void check_result(normal_t got);
      normal_t e;
      checked++;
      if (pending_q.size() == 0) begin
        $error("result with no request pending");
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (e.degen) degen_seen++;
      if (got.nx !== e.nx) begin
        $error("normal_x expected %0d actual %0d", e.nx, got.nx); errors++;
      end
      if (got.ny !== e.ny) begin
        $error("normal_y expected %0d actual %0d", e.ny, got.ny); errors++;
      end
      if (got.nz !== e.nz) begin
        $error("normal_z expected %0d actual %0d", e.nz, got.nz); errors++;
      end
      if (got.degen !== e.degen) begin
        $error("degenerate expected %0d actual %0d", e.degen, got.degen); errors++;
      end
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_COUNT   = 850;

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   start_i = 1'b0;
  logic   busy_o, done_o, degenerate_o;
  coord_t vtx[9];
  logic signed [NORM_W-1:0] normal_x_o, normal_y_o, normal_z_o;

  normal_scoreboard sb = new();
  int  idle_cycles = 0;
  int  sent = 0;

  initial foreach (vtx[i]) vtx[i] = '0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  triangle_face_normal_unit u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .a_x_i(vtx[0]), .a_y_i(vtx[1]), .a_z_i(vtx[2]),
    .b_x_i(vtx[3]), .b_y_i(vtx[4]), .b_z_i(vtx[5]),
    .c_x_i(vtx[6]), .c_y_i(vtx[7]), .c_z_i(vtx[8]),
    .done_o(done_o), .normal_x_o(normal_x_o), .normal_y_o(normal_y_o),
    .normal_z_o(normal_z_o), .degenerate_o(degenerate_o)
  );

  // accept requests and results at the edge, watchdog on no progress
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) sb.note_request(vtx);
      if (done_o) sb.check_result({normal_x_o, normal_y_o, normal_z_o, degenerate_o});
      if ((start_i && !busy_o) || done_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no progress for %0d cycles", WATCHDOG_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // drive one request; without keep_start, start drops for one cycle after it
  task automatic send_triangle(coord_t p[9], bit keep_start);
    start_i <= 1'b1;
    for (int i = 0; i < 9; i++) vtx[i] <= p[i];
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sent++;
    if (!keep_start) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic idle_gap(int n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(0, 255)) - coord_t'(128);
      2: return ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
      default: return coord_t'($urandom_range(0, 15)) - coord_t'(8);
    endcase
  endfunction

  // directed triangles: extremes, axis-aligned, collinear and coincident
  task automatic run_directed();
    coord_t p[9];
    coord_t ext[4] = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff};
    foreach (p[i]) p[i] = '0;
    send_triangle(p, 0);                                   // all coincident
    p = '{0, 0, 0, 256, 0, 0, 0, 256, 0}; send_triangle(p, 1);  // +z
    p = '{0, 0, 0, 0, 256, 0, 256, 0, 0}; send_triangle(p, 1);  // -z
    p = '{0, 0, 0, 0, 256, 0, 0, 0, 256}; send_triangle(p, 1);  // +x
    p = '{0, 0, 0, 0, 0, 256, 256, 0, 0}; send_triangle(p, 0);  // +y
    p = '{0, 0, 0, 1, 1, 1, 2, 2, 2}; send_triangle(p, 0);      // collinear
    p = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000,
          16'sh8000, 16'sh7fff, 16'sh8000};
    send_triangle(p, 1);                                   // widest edges
    p = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff,
          16'sh7fff, 16'sh8000, 16'sh8000};
    send_triangle(p, 1);
    p = '{0, 0, 0, 1, 0, 0, 0, 1, 0}; send_triangle(p, 1);      // tiny
    p = '{0, 0, 0, 1, 2, 0, 2, 1, 0}; send_triangle(p, 0);      // diagonal tie
    for (int k = 0; k < 12; k++) begin
      foreach (p[i]) p[i] = ext[$urandom_range(0, 3)];
      send_triangle(p, k % 3 != 0);
    end
    idle_gap(3);
  endtask

  // random triangles in bursts, some deliberately degenerate
  task automatic run_random();
    coord_t p[9];
    int burst, mode;
    while (sent < RANDOM_COUNT + 22) begin
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst; b++) begin
        mode = $urandom_range(0, 3);
        foreach (p[i]) p[i] = rand_coord(mode);
        if ($urandom_range(0, 15) == 0)
          for (int i = 0; i < 3; i++) p[6+i] = p[3+i];     // repeated vertex
        send_triangle(p, b != burst - 1);
      end
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 12));
    end
    start_i <= 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    run_random();
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
    $display("covered %0d triangles, %0d results checked, %0d degenerate",
             sent, sb.checked, sb.degen_seen);
    if (sb.errors == 0 && sb.pending_q.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
